// ===== sv/vts_pkg.sv =====
// ----------------------------------------------------------------------------
// vts_pkg
// Shared types and constants of the voice table: entry layout, the command
// bundle from the sequencer to the datapath and the status bundle back.
// ----------------------------------------------------------------------------
package vts_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TAG_W       = 16;
  localparam int TIME_W      = 32;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              held;
    logic [TIME_W-1:0] ptime;
  } entry_t;

  typedef struct packed {
    logic load;         // capture the new item, clear flags
    logic set_bad;      // flag a remove out of range
    logic go_shift_rm;  // start a shift at the removed slot
    logic scan_step;    // read and rank the next entry
    logic go_shift_ev;  // latch the victim, start a shift at it
    logic shift_step;   // move the next entry down one place
    logic cnt_dec;      // drop one entry from the count
    logic append;       // write the new entry at the end
  } cmd_t;

  typedef struct packed {
    logic is_remove;
    logic slot_ok;
    logic full;
    logic scan_done;
    logic shift_done;
  } stat_t;

endpackage

// ===== sv/vts_ctrl.sv =====
// ----------------------------------------------------------------------------
// vts_ctrl
// Sequencer of the voice table: walks one operation through decide, victim
// scan, compacting shift and append, then raises the result strobe.
// ----------------------------------------------------------------------------
module vts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  vts_pkg::stat_t stat_i,
  output vts_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_APPEND = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.is_remove) begin
          if (stat_i.slot_ok) begin
            cmd_o.go_shift_rm = 1'b1;
            state_d           = S_SHIFT;
          end else begin
            cmd_o.set_bad = 1'b1;
            state_d       = S_DONE;
          end
        end else if (stat_i.full) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_APPEND;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          cmd_o.go_shift_ev = 1'b1;
          state_d           = S_SHIFT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = stat_i.is_remove ? S_DONE : S_APPEND;
        end else begin
          cmd_o.shift_step = 1'b1;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== sv/vts_dp.sv =====
// ----------------------------------------------------------------------------
// vts_dp
// Datapath of the voice table: entry memory with one registered read port,
// pointer, victim ranking registers, entry count and result registers.
// ----------------------------------------------------------------------------
module vts_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                mode_i,
  input  logic [vts_pkg::IDX_W-1:0]           slot_index_i,
  input  logic [vts_pkg::TAG_W-1:0]           note_tag_i,
  input  logic                                note_held_i,
  input  logic [vts_pkg::TIME_W-1:0]          press_time_i,
  input  vts_pkg::cmd_t                       cmd_i,
  output vts_pkg::stat_t                      stat_o,
  output logic [vts_pkg::CNT_W-1:0]           count_o,
  output logic                                evicted_o,
  output logic [vts_pkg::IDX_W-1:0]           evicted_index_o,
  output logic [vts_pkg::TAG_W-1:0]           evicted_tag_o,
  output logic                                bad_index_o
);

  localparam int IDX_W = vts_pkg::IDX_W;
  localparam int CNT_W = vts_pkg::CNT_W;

  vts_pkg::entry_t mem_q [vts_pkg::TABLE_DEPTH];
  vts_pkg::entry_t rd_data_q;
  vts_pkg::entry_t new_q;

  logic                      mode_q;
  logic [IDX_W-1:0]          slot_q;
  logic [CNT_W-1:0]          count_q;
  logic [CNT_W-1:0]          ptr_q;
  logic                      cmp_vld_q;
  logic [IDX_W-1:0]          cmp_idx_q;
  logic                      wr_vld_q;
  logic [IDX_W-1:0]          wr_addr_q;
  logic                      in_rel_q;
  logic [vts_pkg::TIME_W-1:0] best_time_q;
  logic [IDX_W-1:0]          best_idx_q;
  logic [vts_pkg::TAG_W-1:0] best_tag_q;
  logic                      evicted_q;
  logic                      bad_q;
  logic [IDX_W-1:0]          ev_idx_q;
  logic [vts_pkg::TAG_W-1:0] ev_tag_q;

  logic more;
  logic rd_en;
  logic take;
  logic rel_d;
  logic later;

  assign more  = (ptr_q < count_q);
  assign rd_en = (cmd_i.scan_step | cmd_i.shift_step) & more;
  assign later = (rd_data_q.ptime > best_time_q);

  // Rank one entry: released beats held, later time beats earlier, ties keep
  // the lower index. The first entry always seeds the search.
  always_comb begin
    take  = 1'b0;
    rel_d = in_rel_q;
    if (cmp_idx_q == '0) begin
      take  = 1'b1;
      rel_d = ~rd_data_q.held;
    end else if (rd_data_q.held) begin
      take = ~in_rel_q & later;
    end else if (!in_rel_q) begin
      take  = 1'b1;
      rel_d = 1'b1;
    end else begin
      take = later;
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_vld_q) begin
      mem_q[wr_addr_q] <= rd_data_q;
    end else if (cmd_i.append) begin
      mem_q[count_q[IDX_W-1:0]] <= new_q;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[ptr_q[IDX_W-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q      <= mode_i;
      slot_q      <= slot_index_i;
      new_q.tag   <= note_tag_i;
      new_q.held  <= note_held_i;
      new_q.ptime <= press_time_i;
      ev_idx_q    <= '0;
      ev_tag_q    <= '0;
    end
    if (cmd_i.go_shift_ev) begin
      ev_idx_q <= best_idx_q;
      ev_tag_q <= best_tag_q;
    end
    cmp_idx_q <= ptr_q[IDX_W-1:0];
    wr_addr_q <= ptr_q[IDX_W-1:0] - IDX_W'(1);
    if (cmp_vld_q) begin
      in_rel_q <= rel_d;
      if (take) begin
        best_time_q <= rd_data_q.ptime;
        best_idx_q  <= cmp_idx_q;
        best_tag_q  <= rd_data_q.tag;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ptr_q     <= '0;
      cmp_vld_q <= 1'b0;
      wr_vld_q  <= 1'b0;
      evicted_q <= 1'b0;
      bad_q     <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_step & more;
      wr_vld_q  <= cmd_i.shift_step & more;
      if (cmd_i.load) begin
        ptr_q     <= '0;
        evicted_q <= 1'b0;
        bad_q     <= 1'b0;
      end else if (cmd_i.go_shift_rm) begin
        ptr_q <= CNT_W'(slot_q) + CNT_W'(1);
      end else if (cmd_i.go_shift_ev) begin
        ptr_q     <= CNT_W'(best_idx_q) + CNT_W'(1);
        evicted_q <= 1'b1;
      end else if (rd_en) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      if (cmd_i.set_bad) begin
        bad_q <= 1'b1;
      end
      if (cmd_i.cnt_dec) begin
        count_q <= count_q - CNT_W'(1);
      end else if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign stat_o.is_remove  = mode_q;
  assign stat_o.slot_ok    = (CNT_W'(slot_q) < count_q);
  assign stat_o.full       = (count_q == CNT_W'(vts_pkg::TABLE_DEPTH));
  assign stat_o.scan_done  = ~more & ~cmp_vld_q;
  assign stat_o.shift_done = ~more & ~wr_vld_q;

  assign count_o         = count_q;
  assign evicted_o       = evicted_q;
  assign evicted_index_o = ev_idx_q;
  assign evicted_tag_o   = ev_tag_q;
  assign bad_index_o     = bad_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(vts_pkg::TABLE_DEPTH))
    else $error("entry count above table depth");

  a_one_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_vld_q && cmd_i.append))
    else $error("shift write and append collide");

  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.go_shift_ev |-> count_q == CNT_W'(vts_pkg::TABLE_DEPTH))
    else $error("victim taken from a table that is not full");

  a_pipes_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> !wr_vld_q)
    else $error("scan and shift active together");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("append did not grow the count");
`endif

endmodule

// ===== sv/voice_table_with_stealing_top.sv =====
// ----------------------------------------------------------------------------
// voice_table_with_stealing_top
// Packed table of active notes with voice stealing on a full table.
// ----------------------------------------------------------------------------
// Throughput: one operation at a time; start is taken again the cycle after
// done_o. The victim scan reads one entry per cycle through the single memory
// read port, and the compacting shift moves one entry per cycle.
// Reset: rst_ni clears the count and the sequencer; entry contents stay as is.
// Results are not back-pressured: done_o marks one cycle and the transfer is
// complete at its closing edge.
module voice_table_with_stealing_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command side: a transfer happens when start is high and busy is low
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode_i,
  input  logic [vts_pkg::IDX_W-1:0]     slot_index_i,
  input  logic [vts_pkg::TAG_W-1:0]     note_tag_i,
  input  logic                          note_held_i,
  input  logic [vts_pkg::TIME_W-1:0]    press_time_i,
  // result side: valid for exactly the done_o cycle
  output logic                          done_o,
  output logic [vts_pkg::CNT_W-1:0]     count_o,
  output logic                          evicted_o,
  output logic [vts_pkg::IDX_W-1:0]     evicted_index_o,
  output logic [vts_pkg::TAG_W-1:0]     evicted_tag_o,
  output logic                          bad_index_o
);

  vts_pkg::cmd_t  cmd;
  vts_pkg::stat_t stat;

  // Sequencer: decides between append, remove, and scan plus shift, and
  // raises busy for the whole operation so no new item can slip in.
  vts_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Datapath: holds the entries, ranks victims as they stream out of the
  // memory and compacts the table by moving each later entry down one slot.
  // The result registers hold their value until the next operation starts.
  vts_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (mode_i),
    .slot_index_i    (slot_index_i),
    .note_tag_i      (note_tag_i),
    .note_held_i     (note_held_i),
    .press_time_i    (press_time_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .count_o         (count_o),
    .evicted_o       (evicted_o),
    .evicted_index_o (evicted_index_o),
    .evicted_tag_o   (evicted_tag_o),
    .bad_index_o     (bad_index_o)
  );

endmodule

// ===== sim/tb_voice_table_with_stealing_top.sv =====
// ----------------------------------------------------------------------------
// tb_voice_table_with_stealing_top
// Self-checking bench for the voice table with voice stealing. A shadow copy
// of the note table predicts count, steal and out-of-range status for every
// accepted command. A monitor compares each done_o strobe against the oldest
// prediction. Stimulus runs a directed part for the edge cases, then random
// add/remove traffic with a drifting add rate and random sender gaps.
// ----------------------------------------------------------------------------
module tb_voice_table_with_stealing_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = vts_pkg::TABLE_DEPTH;
  localparam int IDX_W       = vts_pkg::IDX_W;
  localparam int CNT_W       = vts_pkg::CNT_W;
  localparam int TAG_W       = vts_pkg::TAG_W;
  localparam int TIME_W      = vts_pkg::TIME_W;

  // Command codes on mode_i
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Longest operation is a full-table add; allow margin for the drain tail
  localparam int unsigned TAIL_CYCLES  = 48;
  // Cycles without any transfer before the run is declared hung
  localparam int unsigned STALL_LIMIT  = 1000;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             evicted;
    logic [IDX_W-1:0] ev_index;
    logic [TAG_W-1:0] ev_tag;
    logic             bad;
  } voice_status_t;

  // DUT signals; the inputs are known from time zero
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic              mode_i       = MODE_ADD;
  logic [IDX_W-1:0]  slot_index_i = '0;
  logic [TAG_W-1:0]  note_tag_i   = '0;
  logic              note_held_i  = 1'b0;
  logic [TIME_W-1:0] press_time_i = '0;
  logic              done_o;
  logic [CNT_W-1:0]  count_o;
  logic              evicted_o;
  logic [IDX_W-1:0]  evicted_index_o;
  logic [TAG_W-1:0]  evicted_tag_o;
  logic              bad_index_o;

  // Shadow table and the status predictions waiting for done_o
  vts_pkg::entry_t   shadow_voices [TABLE_DEPTH];
  int unsigned       shadow_count = 0;
  voice_status_t     pending_status [$];

  int unsigned       mismatch_cnt = 0;
  int unsigned       cmd_cnt      = 0;
  int unsigned       steal_cnt    = 0;
  int unsigned       bad_rm_cnt   = 0;
  int unsigned       idle_cycles  = 0;
  bit                idle_en      = 1'b1;

  voice_table_with_stealing_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .slot_index_i    (slot_index_i),
    .note_tag_i      (note_tag_i),
    .note_held_i     (note_held_i),
    .press_time_i    (press_time_i),
    .done_o          (done_o),
    .count_o         (count_o),
    .evicted_o       (evicted_o),
    .evicted_index_o (evicted_index_o),
    .evicted_tag_o   (evicted_tag_o),
    .bad_index_o     (bad_index_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow table
  // --------------------------------------------------------------------------

  // Drop the entry at pos and close the gap by moving later entries down.
  function automatic void compact_out(input int unsigned pos);
    for (int unsigned k = pos; k + 1 < shadow_count; k++) begin
      shadow_voices[k] = shadow_voices[k + 1];
    end
    if (shadow_count != 0) shadow_count--;
  endfunction

  // Choose the voice to steal: any released entry beats every held one;
  // inside the winning class the latest press wins, ties keep the lowest
  // index. With only held entries all at time zero the result stays 0.
  function automatic int unsigned pick_steal_slot();
    bit                released_seen;
    logic [TIME_W-1:0] best_time;
    int unsigned       best;
    released_seen = 1'b0;
    best_time     = '0;
    best          = 0;
    for (int unsigned k = 0; k < shadow_count; k++) begin
      if (shadow_voices[k].held) begin
        if (!released_seen && shadow_voices[k].ptime > best_time) begin
          best_time = shadow_voices[k].ptime;
          best      = k;
        end
      end else if (!released_seen) begin
        released_seen = 1'b1;
        best_time     = shadow_voices[k].ptime;
        best          = k;
      end else if (shadow_voices[k].ptime > best_time) begin
        best_time = shadow_voices[k].ptime;
        best      = k;
      end
    end
    return best;
  endfunction

  // Apply one accepted command to the shadow table and return its status.
  function automatic voice_status_t apply_voice_cmd(
    input logic              m,
    input logic [IDX_W-1:0]  s,
    input logic [TAG_W-1:0]  t,
    input logic              h,
    input logic [TIME_W-1:0] pt
  );
    voice_status_t st;
    int unsigned   victim;
    st = '0;
    if (m == MODE_REMOVE) begin
      if (s >= shadow_count) begin
        st.bad = 1'b1;
        bad_rm_cnt++;
      end else begin
        compact_out(s);
      end
    end else begin
      if (shadow_count >= TABLE_DEPTH) begin
        victim      = pick_steal_slot();
        st.evicted  = 1'b1;
        st.ev_index = victim[IDX_W-1:0];
        st.ev_tag   = shadow_voices[victim].tag;
        steal_cnt++;
        compact_out(victim);
      end
      shadow_voices[shadow_count].tag   = t;
      shadow_voices[shadow_count].held  = h;
      shadow_voices[shadow_count].ptime = pt;
      shadow_count++;
    end
    st.count = shadow_count[CNT_W-1:0];
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one command, hold it until the transfer edge, record the
  // prediction at that edge. Keep start high when no gap follows so the
  // next command never sees start dropped and raised in one step.
  task automatic send_cmd(
    input logic              m,
    input logic [IDX_W-1:0]  s,
    input logic [TAG_W-1:0]  t,
    input logic              h,
    input logic [TIME_W-1:0] pt
  );
    int unsigned gap;
    start        <= 1'b1;
    mode_i       <= m;
    slot_index_i <= s;
    note_tag_i   <= t;
    note_held_i  <= h;
    press_time_i <= pt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_status.push_back(apply_voice_cmd(m, s, t, h, pt));
    cmd_cnt++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and hold until every predicted status has been seen.
  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Result monitor: done_o is never held off, so sample every strobe
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    voice_status_t want;
    if (rst_ni && done_o) begin
      if (pending_status.size() == 0) begin
        $error("done_o strobe with no command outstanding (count_o %0d)", count_o);
        mismatch_cnt++;
      end else begin
        want = pending_status.pop_front();
        check_field("count",         32'(want.count),    32'(count_o));
        check_field("evicted",       32'(want.evicted),  32'(evicted_o));
        check_field("evicted_index", 32'(want.ev_index), 32'(evicted_index_o));
        check_field("evicted_tag",   32'(want.ev_tag),   32'(evicted_tag_o));
        check_field("bad_index",     32'(want.bad),      32'(bad_index_o));
      end
    end
  end

  // Watchdog: count cycles with neither a command nor a result transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_status.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Removes on an empty and a short table, extreme field values.
  task automatic test_empty_and_edges();
    send_cmd(MODE_REMOVE, 4'd0,  16'h1234, 1'b1, 32'd0);        // remove on empty
    send_cmd(MODE_ADD,    4'd9,  16'h0000, 1'b1, 32'd0);
    send_cmd(MODE_ADD,    4'd0,  16'hFFFF, 1'b0, 32'hFFFF_FFFF);
    send_cmd(MODE_REMOVE, 4'd15, 16'hFFFF, 1'b0, 32'hFFFF_FFFF); // index past count
    send_cmd(MODE_REMOVE, 4'd1,  16'h0000, 1'b0, 32'd0);        // last entry
    send_cmd(MODE_REMOVE, 4'd0,  16'h0000, 1'b0, 32'd0);        // back to empty
  endtask

  // Fill the table, then steal under each ranking rule.
  task automatic test_steal_rules();
    for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
      send_cmd(MODE_ADD, 4'(k), 16'h0100 + 16'(k), 1'b1, 32'd0);
    end
    // all held at time zero: fall back to index 0
    send_cmd(MODE_ADD, 4'd0, 16'hA005, 1'b1, 32'd5);
    // the latest held press goes
    send_cmd(MODE_ADD, 4'd0, 16'hB000, 1'b0, 32'd0);
    // a released entry goes even with the earliest time
    send_cmd(MODE_ADD, 4'd0, 16'hC009, 1'b1, 32'd9);
  endtask

  // Random add/remove mix. The add rate drifts per block so the table swings
  // between empty and full; small time values force ties in the ranking.
  task automatic test_random_traffic(input int unsigned n_cmds);
    int unsigned       add_pct;
    int unsigned       r;
    logic              m;
    logic [IDX_W-1:0]  s;
    logic [TIME_W-1:0] pt;
    add_pct = 55;
    for (int unsigned i = 0; i < n_cmds; i++) begin
      if (i % 64 == 0) begin
        add_pct = $urandom_range(30, 80);
        idle_en = ($urandom_range(0, 3) != 0);
      end
      m = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_REMOVE;
      if (shadow_count != 0 && $urandom_range(0, 99) < 85) begin
        s = IDX_W'($urandom_range(0, shadow_count - 1));
      end else begin
        s = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
      end
      r = $urandom_range(0, 9);
      if (r < 5)       pt = TIME_W'($urandom_range(0, 7));
      else if (r == 5) pt = '0;
      else if (r == 6) pt = '1;
      else             pt = TIME_W'($urandom);
      send_cmd(m, s, TAG_W'($urandom), ($urandom_range(0, 9) < 7), pt);
    end
  endtask

  // Stop sending until the block has answered everything, then resume.
  task automatic test_drain_pause();
    wait_results_drained();
    repeat ($urandom_range(1, 5)) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_edges();
    test_steal_rules();
    test_random_traffic(450);
    test_drain_pause();
    test_random_traffic(450);

    // flush: wait out the outstanding results plus one worst-case latency
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (pending_status.size() != 0) begin
      $error("%0d predicted results never arrived", pending_status.size());
      mismatch_cnt++;
    end

    $display("Ran %0d add/remove commands: %0d voice steals, %0d out-of-range removes,",
             cmd_cnt, steal_cnt, bad_rm_cnt);
    $display("with random sender gaps and one full drain pause; %0d mismatches.",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
